FILE: hw/rtl/lr_shift_reduce_parser_assert.svh
// Assertion macros shared by the checker files of the parse engine.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef LR_SHIFT_REDUCE_PARSER_ASSERT_SVH
`define LR_SHIFT_REDUCE_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge.
`define LRP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define LRP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/lrp_pkg.sv
package lrp_pkg;

	// Field widths
	localparam int ST_W   = 6;
	localparam int COL_W  = 4;
	localparam int NT_W   = 4;
	localparam int PROD_W = 6;
	localparam int KIND_W = 2;
	localparam int LEN_W  = 4;
	localparam int RK_W   = 3;
	localparam int EC_W   = 3;

	// Table and stack sizes
	localparam int NUM_STATES       = 64;
	localparam int NUM_TERMINALS    = 16;
	localparam int NUM_NONTERMINALS = 16;
	localparam int NUM_PRODUCTIONS  = 64;
	localparam int STACK_DEPTH      = 64;
	localparam int MAX_CHAIN        = 62;

	localparam int ACT_AW   = ST_W + COL_W;
	localparam int GOTO_AW  = ST_W + NT_W;
	localparam int SP_W     = $clog2(STACK_DEPTH);
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int CHAIN_W  = $clog2(MAX_CHAIN + 1);

	// Item opcodes
	localparam logic [1:0] OP_ACT_WR  = 2'd0;
	localparam logic [1:0] OP_GOTO_WR = 2'd1;
	localparam logic [1:0] OP_PROD_WR = 2'd2;
	localparam logic [1:0] OP_TOKEN   = 2'd3;

	// Action kinds
	localparam logic [KIND_W-1:0] AK_ERROR  = 2'd0;
	localparam logic [KIND_W-1:0] AK_SHIFT  = 2'd1;
	localparam logic [KIND_W-1:0] AK_REDUCE = 2'd2;
	localparam logic [KIND_W-1:0] AK_ACCEPT = 2'd3;

	// Result kinds
	localparam logic [RK_W-1:0] RK_WRITE  = 3'd0;
	localparam logic [RK_W-1:0] RK_SHIFT  = 3'd1;
	localparam logic [RK_W-1:0] RK_REDUCE = 3'd2;
	localparam logic [RK_W-1:0] RK_ACCEPT = 3'd3;
	localparam logic [RK_W-1:0] RK_ERROR  = 3'd4;

	// Error causes
	localparam logic [EC_W-1:0] EC_NONE      = 3'd0;
	localparam logic [EC_W-1:0] EC_ENTRY     = 3'd1;
	localparam logic [EC_W-1:0] EC_OVERFLOW  = 3'd2;
	localparam logic [EC_W-1:0] EC_UNDERFLOW = 3'd3;
	localparam logic [EC_W-1:0] EC_CHAIN     = 3'd4;

	// Table write port
	typedef struct packed {
		logic              act_we;
		logic              goto_we;
		logic              prod_we;
		logic [ST_W-1:0]   row;
		logic [COL_W-1:0]  col;
		logic [PROD_W-1:0] pid;
		logic [KIND_W-1:0] kind;
		logic [ST_W-1:0]   val;
		logic [NT_W-1:0]   lhs;
		logic [LEN_W-1:0]  len;
	} tbl_wr_t;

	// Table read addresses
	typedef struct packed {
		logic [ACT_AW-1:0]  act;
		logic [PROD_W-1:0]  prod;
		logic [GOTO_AW-1:0] gto;
	} tbl_ra_t;

	// Table read data
	typedef struct packed {
		logic [KIND_W-1:0] act_kind;
		logic [ST_W-1:0]   act_val;
		logic [NT_W-1:0]   prod_lhs;
		logic [LEN_W-1:0]  prod_len;
		logic [ST_W-1:0]   goto_state;
	} tbl_rd_t;

	// Stack memory command
	typedef struct packed {
		logic            we;
		logic [SP_W-1:0] waddr;
		logic [ST_W-1:0] wdata;
		logic [SP_W-1:0] raddr;
	} stk_cmd_t;

	// One result item
	typedef struct packed {
		logic [RK_W-1:0]   kind;
		logic [PROD_W-1:0] prod;
		logic [ST_W-1:0]   top;
		logic [CNT_W-1:0]  depth;
		logic [EC_W-1:0]   cause;
		logic              last;
	} res_t;

endpackage

FILE: hw/rtl/lrp_tables.sv
// Action, goto and production memories: one write and one registered read each.
module lrp_tables (
	input  logic            clk,
	input  lrp_pkg::tbl_wr_t wr,
	input  lrp_pkg::tbl_ra_t ra,
	output lrp_pkg::tbl_rd_t rd
);

	logic [lrp_pkg::KIND_W+lrp_pkg::ST_W-1:0] act_mem [lrp_pkg::NUM_STATES*lrp_pkg::NUM_TERMINALS];
	logic [lrp_pkg::ST_W-1:0] goto_mem [lrp_pkg::NUM_STATES*lrp_pkg::NUM_NONTERMINALS];
	logic [lrp_pkg::NT_W+lrp_pkg::LEN_W-1:0] prod_mem [lrp_pkg::NUM_PRODUCTIONS];

	logic [lrp_pkg::KIND_W+lrp_pkg::ST_W-1:0] act_rd_q;
	logic [lrp_pkg::ST_W-1:0]                 goto_rd_q;
	logic [lrp_pkg::NT_W+lrp_pkg::LEN_W-1:0]  prod_rd_q;

	// action table
	always_ff @(posedge clk) begin
		if (wr.act_we) begin
			act_mem[{wr.row, wr.col}] <= {wr.kind, wr.val};
		end
		act_rd_q <= act_mem[ra.act];
	end

	// goto table
	always_ff @(posedge clk) begin
		if (wr.goto_we) begin
			goto_mem[{wr.row, wr.col}] <= wr.val;
		end
		goto_rd_q <= goto_mem[ra.gto];
	end

	// productions
	always_ff @(posedge clk) begin
		if (wr.prod_we) begin
			prod_mem[wr.pid] <= {wr.lhs, wr.len};
		end
		prod_rd_q <= prod_mem[ra.prod];
	end

	assign rd.act_kind   = act_rd_q[lrp_pkg::KIND_W+lrp_pkg::ST_W-1:lrp_pkg::ST_W];
	assign rd.act_val    = act_rd_q[lrp_pkg::ST_W-1:0];
	assign rd.prod_lhs   = prod_rd_q[lrp_pkg::NT_W+lrp_pkg::LEN_W-1:lrp_pkg::LEN_W];
	assign rd.prod_len   = prod_rd_q[lrp_pkg::LEN_W-1:0];
	assign rd.goto_state = goto_rd_q;

endmodule

FILE: hw/rtl/lrp_stack.sv
// State stack memory. Entry zero is never written by the sequencer, and a read
// of address zero is answered with zero, so it always stands for state 0.
module lrp_stack (
	input  logic                     clk,
	input  lrp_pkg::stk_cmd_t        cmd,
	output logic [lrp_pkg::ST_W-1:0] rdata
);

	logic [lrp_pkg::ST_W-1:0] stk_mem [lrp_pkg::STACK_DEPTH];
	logic [lrp_pkg::ST_W-1:0] rd_q;
	logic                     rd_zero_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			stk_mem[cmd.waddr] <= cmd.wdata;
		end
		rd_q      <= stk_mem[cmd.raddr];
		rd_zero_q <= (cmd.raddr == '0);
	end

	assign rdata = rd_zero_q ? '0 : rd_q;

endmodule

FILE: hw/rtl/lrp_ctrl.sv
// Parse sequencer: decodes items, walks the reduce chain, keeps top and depth.
module lrp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [lrp_pkg::ST_W-1:0]   row_state,
	input  logic [lrp_pkg::COL_W-1:0]  column,
	input  logic [lrp_pkg::PROD_W-1:0] production_id,
	input  logic [lrp_pkg::KIND_W-1:0] entry_kind,
	input  logic [lrp_pkg::ST_W-1:0]   entry_value,
	input  logic [lrp_pkg::NT_W-1:0]   lhs_symbol,
	input  logic [lrp_pkg::LEN_W-1:0]  rhs_length,
	input  logic                       can_emit,
	output logic                       emit,
	output lrp_pkg::res_t              res,
	output lrp_pkg::tbl_wr_t           tbl_wr,
	output lrp_pkg::tbl_ra_t           tbl_ra,
	input  lrp_pkg::tbl_rd_t           tbl_rd,
	output lrp_pkg::stk_cmd_t          stk_cmd,
	input  logic [lrp_pkg::ST_W-1:0]   stk_rdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACT   = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_PROD  = 3'd3;
	localparam logic [2:0] S_UNDER = 3'd4;
	localparam logic [2:0] S_GOTO  = 3'd5;

	localparam logic [lrp_pkg::CNT_W-1:0] FULL = lrp_pkg::CNT_W'(lrp_pkg::STACK_DEPTH);
	localparam logic [lrp_pkg::CHAIN_W-1:0] CHAIN_LIM =
		lrp_pkg::CHAIN_W'(lrp_pkg::MAX_CHAIN);

	logic [2:0]                    state_q, state_d;
	logic [lrp_pkg::ST_W-1:0]      top_q, top_d;
	logic [lrp_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [lrp_pkg::CHAIN_W-1:0]   chain_q, chain_d;
	logic [lrp_pkg::COL_W-1:0]     col_q, col_d;

	logic                          accept;
	logic                          err_fire;
	logic                          restart;
	logic [lrp_pkg::EC_W-1:0]      err_cause;
	logic [lrp_pkg::CNT_W-1:0]     plen_ext;
	logic [lrp_pkg::CNT_W-1:0]     base_cnt;
	logic [lrp_pkg::CNT_W-1:0]     under_idx;

	assign in_stall = !((state_q == S_IDLE) && can_emit);
	assign accept   = in_valid && !in_stall;

	// table writes straight from the accepted item
	always_comb begin
		tbl_wr.act_we  = accept && (op == lrp_pkg::OP_ACT_WR);
		tbl_wr.goto_we = accept && (op == lrp_pkg::OP_GOTO_WR);
		tbl_wr.prod_we = accept && (op == lrp_pkg::OP_PROD_WR);
		tbl_wr.row     = row_state;
		tbl_wr.col     = column;
		tbl_wr.pid     = production_id;
		tbl_wr.kind    = entry_kind;
		tbl_wr.val     = entry_value;
		tbl_wr.lhs     = lhs_symbol;
		tbl_wr.len     = rhs_length;
	end

	// stack arithmetic for the reduce in flight
	assign plen_ext  = lrp_pkg::CNT_W'(tbl_rd.prod_len);
	assign base_cnt  = cnt_q - plen_ext;
	assign under_idx = base_cnt - lrp_pkg::CNT_W'(1);

	// read addresses follow the held registers
	assign tbl_ra.act  = {top_q, col_q};
	assign tbl_ra.prod = tbl_rd.act_val;
	assign tbl_ra.gto  = {stk_rdata, tbl_rd.prod_lhs};

	// sequencer
	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		cnt_d     = cnt_q;
		chain_d   = chain_q;
		col_d     = col_q;
		emit      = 1'b0;
		err_fire  = 1'b0;
		restart   = 1'b0;
		err_cause = lrp_pkg::EC_NONE;
		res.kind  = lrp_pkg::RK_WRITE;
		res.prod  = '0;
		res.top   = top_q;
		res.depth = cnt_q;
		res.cause = lrp_pkg::EC_NONE;
		res.last  = 1'b1;
		stk_cmd.we    = 1'b0;
		stk_cmd.waddr = cnt_q[lrp_pkg::SP_W-1:0];
		stk_cmd.wdata = tbl_rd.act_val;
		stk_cmd.raddr = under_idx[lrp_pkg::SP_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == lrp_pkg::OP_TOKEN) begin
						col_d   = column;
						chain_d = '0;
						state_d = S_ACT;
					end else begin
						emit = 1'b1;
					end
				end
			end
			S_ACT: begin
				state_d = S_DEC;
			end
			S_DEC: begin
				if (can_emit) begin
					case (tbl_rd.act_kind)
						lrp_pkg::AK_ERROR: begin
							err_fire  = 1'b1;
							err_cause = lrp_pkg::EC_ENTRY;
						end
						lrp_pkg::AK_SHIFT: begin
							if (cnt_q >= FULL) begin
								err_fire  = 1'b1;
								err_cause = lrp_pkg::EC_OVERFLOW;
							end else begin
								stk_cmd.we = 1'b1;
								top_d      = tbl_rd.act_val;
								cnt_d      = cnt_q + lrp_pkg::CNT_W'(1);
								emit       = 1'b1;
								res.kind   = lrp_pkg::RK_SHIFT;
								res.top    = tbl_rd.act_val;
								res.depth  = cnt_q + lrp_pkg::CNT_W'(1);
								state_d    = S_IDLE;
							end
						end
						lrp_pkg::AK_ACCEPT: begin
							emit     = 1'b1;
							restart  = 1'b1;
							res.kind = lrp_pkg::RK_ACCEPT;
							state_d  = S_IDLE;
						end
						lrp_pkg::AK_REDUCE: begin
							if (chain_q >= CHAIN_LIM) begin
								err_fire  = 1'b1;
								err_cause = lrp_pkg::EC_CHAIN;
							end else begin
								state_d = S_PROD;
							end
						end
						default: begin
							err_fire  = 1'b1;
							err_cause = lrp_pkg::EC_ENTRY;
						end
					endcase
				end
			end
			S_PROD: begin
				if (can_emit) begin
					if (plen_ext >= cnt_q) begin
						err_fire  = 1'b1;
						err_cause = lrp_pkg::EC_UNDERFLOW;
					end else if ((plen_ext == '0) && (cnt_q >= FULL)) begin
						err_fire  = 1'b1;
						err_cause = lrp_pkg::EC_OVERFLOW;
					end else begin
						state_d = S_UNDER;
					end
				end
			end
			S_UNDER: begin
				state_d = S_GOTO;
			end
			S_GOTO: begin
				if (can_emit) begin
					stk_cmd.we    = 1'b1;
					stk_cmd.waddr = base_cnt[lrp_pkg::SP_W-1:0];
					stk_cmd.wdata = tbl_rd.goto_state;
					top_d         = tbl_rd.goto_state;
					cnt_d         = base_cnt + lrp_pkg::CNT_W'(1);
					chain_d       = chain_q + lrp_pkg::CHAIN_W'(1);
					emit          = 1'b1;
					res.kind      = lrp_pkg::RK_REDUCE;
					res.prod      = tbl_rd.act_val;
					res.top       = tbl_rd.goto_state;
					res.depth     = base_cnt + lrp_pkg::CNT_W'(1);
					res.last      = 1'b0;
					state_d       = S_ACT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// error result reports the stack as it stood, then restarts
		if (err_fire) begin
			emit      = 1'b1;
			restart   = 1'b1;
			res.kind  = lrp_pkg::RK_ERROR;
			res.cause = err_cause;
			state_d   = S_IDLE;
		end
		if (restart) begin
			top_d = '0;
			cnt_d = lrp_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			top_q   <= '0;
			cnt_q   <= lrp_pkg::CNT_W'(1);
			chain_q <= '0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			cnt_q   <= cnt_d;
			chain_q <= chain_d;
		end
	end

	always_ff @(posedge clk) begin
		col_q <= col_d;
	end

endmodule

FILE: hw/rtl/lr_shift_reduce_parser.sv
// Table-driven LR shift-reduce parse engine.
// Input channel (in_valid / in_stall) takes one item per handshake: an action,
// goto or production table write, or a token carrying a terminal column.
// Output channel (out_valid / out_stall) gives result items from one output
// register; every item ends with a result whose last bit is set.
// A table write is acknowledged in the cycle after it is taken.
// A token's shift, accept or error result follows its action read and decode
// when no reduction is needed; each reduction adds action, production, stack
// and goto reads through registered memories, one after the other.
// One item is worked at a time: in_stall stays high until its final result
// has been handed to the output register.
// When out_stall holds a result, the sequencer waits before producing the
// next one; nothing is dropped.
// Reset leaves the stack holding state 0 alone; the tables hold nothing
// defined until written, and no clearing pass runs.
module lr_shift_reduce_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [lrp_pkg::ST_W-1:0]   row_state,
	input  logic [lrp_pkg::COL_W-1:0]  column,
	input  logic [lrp_pkg::PROD_W-1:0] production_id,
	input  logic [lrp_pkg::KIND_W-1:0] entry_kind,
	input  logic [lrp_pkg::ST_W-1:0]   entry_value,
	input  logic [lrp_pkg::NT_W-1:0]   lhs_symbol,
	input  logic [lrp_pkg::LEN_W-1:0]  rhs_length,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lrp_pkg::RK_W-1:0]   result_kind,
	output logic [lrp_pkg::PROD_W-1:0] reduced_production,
	output logic [lrp_pkg::ST_W-1:0]   top_state,
	output logic [lrp_pkg::CNT_W-1:0]  depth,
	output logic [lrp_pkg::EC_W-1:0]   error_cause,
	output logic                       last
);

	lrp_pkg::tbl_wr_t  tbl_wr;
	lrp_pkg::tbl_ra_t  tbl_ra;
	lrp_pkg::tbl_rd_t  tbl_rd;
	lrp_pkg::stk_cmd_t stk_cmd;
	lrp_pkg::res_t     res;
	lrp_pkg::res_t     res_q;
	logic [lrp_pkg::ST_W-1:0] stk_rdata;
	logic                     emit;
	logic                     can_emit;
	logic                     out_valid_q;

	lrp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.row_state     (row_state),
		.column        (column),
		.production_id (production_id),
		.entry_kind    (entry_kind),
		.entry_value   (entry_value),
		.lhs_symbol    (lhs_symbol),
		.rhs_length    (rhs_length),
		.can_emit      (can_emit),
		.emit          (emit),
		.res           (res),
		.tbl_wr        (tbl_wr),
		.tbl_ra        (tbl_ra),
		.tbl_rd        (tbl_rd),
		.stk_cmd       (stk_cmd),
		.stk_rdata     (stk_rdata)
	);

	lrp_tables u_tables (
		.clk (clk),
		.wr  (tbl_wr),
		.ra  (tbl_ra),
		.rd  (tbl_rd)
	);

	lrp_stack u_stack (
		.clk   (clk),
		.cmd   (stk_cmd),
		.rdata (stk_rdata)
	);

	// output register: free when empty or being taken this cycle
	assign can_emit = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign result_kind        = res_q.kind;
	assign reduced_production = res_q.prod;
	assign top_state          = res_q.top;
	assign depth              = res_q.depth;
	assign error_cause        = res_q.cause;
	assign last               = res_q.last;

endmodule

FILE: hw/rtl/lrp_checker.sv
`include "lr_shift_reduce_parser_assert.svh"

// Port-level checks on the parse engine's result stream.
module lrp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [lrp_pkg::RK_W-1:0]   result_kind,
	input logic [lrp_pkg::PROD_W-1:0] reduced_production,
	input logic [lrp_pkg::ST_W-1:0]   top_state,
	input logic [lrp_pkg::CNT_W-1:0]  depth,
	input logic [lrp_pkg::EC_W-1:0]   error_cause,
	input logic                       last
);

	// a held result stays valid and keeps its kind, top state and depth
	`LRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_kind) && $stable(top_state) && $stable(depth), "result changed while stalled")

	// the stack never reports empty or beyond its depth
	`LRP_ASSERT_ALWAYS(a_depth_range, !out_valid || ((depth != '0) && (depth <= lrp_pkg::CNT_W'(lrp_pkg::STACK_DEPTH))), "depth out of range")

	// only error results carry a cause
	`LRP_ASSERT_ALWAYS(a_cause_kind, !out_valid || ((result_kind == lrp_pkg::RK_ERROR) == (error_cause != lrp_pkg::EC_NONE)), "cause does not match kind")

	// reductions continue the chain, every other result ends the item
	`LRP_ASSERT_ALWAYS(a_last_kind, !out_valid || ((result_kind == lrp_pkg::RK_REDUCE) == !last), "last does not match kind")

	// a result other than a reduce, such as a write acknowledge, reports no production
	`LRP_ASSERT_ALWAYS(a_prod_zero, !out_valid || (result_kind == lrp_pkg::RK_REDUCE) || (reduced_production == '0), "production on non-reduce result")

endmodule

bind lr_shift_reduce_parser lrp_checker u_lrp_checker (.*);

FILE: test/lr_shift_reduce_parser_tb.sv
`timescale 1ns / 100ps

module lr_shift_reduce_parser_tb;
	import lrp_pkg::*;

	// One input item, in port order
	typedef struct packed {
		logic [1:0]        op;
		logic [ST_W-1:0]   row;
		logic [COL_W-1:0]  col;
		logic [PROD_W-1:0] pid;
		logic [KIND_W-1:0] kind;
		logic [ST_W-1:0]   val;
		logic [NT_W-1:0]   lhs;
		logic [LEN_W-1:0]  len;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ST_W-1:0]   val;
	} action_t;

	typedef struct packed {
		logic [NT_W-1:0]  lhs;
		logic [LEN_W-1:0] len;
	} rule_t;

	// Which table a token would read before anything was written there
	typedef enum int {UNSET_NONE, UNSET_ACTION, UNSET_RULE, UNSET_GOTO} unset_read_t;

	localparam int TIMEOUT_NS = 50_000_000;
	localparam int MAX_REPORTS = 40;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          op;
	logic [ST_W-1:0]     row_state;
	logic [COL_W-1:0]    column;
	logic [PROD_W-1:0]   production_id;
	logic [KIND_W-1:0]   entry_kind;
	logic [ST_W-1:0]     entry_value;
	logic [NT_W-1:0]     lhs_symbol;
	logic [LEN_W-1:0]    rhs_length;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [RK_W-1:0]     result_kind;
	logic [PROD_W-1:0]   reduced_production;
	logic [ST_W-1:0]     top_state;
	logic [CNT_W-1:0]    depth;
	logic [EC_W-1:0]     error_cause;
	logic                last;

	// Parser state as the testbench sees it
	logic [ST_W-1:0] parse_stack [STACK_DEPTH];
	int              parse_depth;
	action_t         action_tbl [NUM_STATES*NUM_TERMINALS];
	bit              action_known [NUM_STATES*NUM_TERMINALS];
	logic [ST_W-1:0] goto_tbl [NUM_STATES*NUM_NONTERMINALS];
	bit              goto_known [NUM_STATES*NUM_NONTERMINALS];
	rule_t           rule_tbl [NUM_PRODUCTIONS];
	bit              rule_known [NUM_PRODUCTIONS];
	res_t            awaited_results [$];

	int items_taken = 0;
	int fail_count = 0;
	bit steady = 1'b0;
	int stall_run = 0;
	bit stall_level = 1'b0;
	int stall_pick;

	lr_shift_reduce_parser dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.row_state          (row_state),
		.column             (column),
		.production_id      (production_id),
		.entry_kind         (entry_kind),
		.entry_value        (entry_value),
		.lhs_symbol         (lhs_symbol),
		.rhs_length         (rhs_length),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.result_kind        (result_kind),
		.reduced_production (reduced_production),
		.top_state          (top_state),
		.depth              (depth),
		.error_cause        (error_cause),
		.last               (last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic res_t make_result(input logic [RK_W-1:0] kind,
			input logic [PROD_W-1:0] prod, input logic [ST_W-1:0] top, input int cnt,
			input logic [EC_W-1:0] cause, input logic fin);
		res_t r;
		r.kind = kind;
		r.prod = prod;
		r.top = top;
		r.depth = CNT_W'(cnt);
		r.cause = cause;
		r.last = fin;
		return r;
	endfunction

	// Runs one token through the tables. With commit clear nothing changes and the
	// call only reports the first read of an entry that was never written.
	function automatic bit parse_token(input logic [COL_W-1:0] col, input bit commit,
			output unset_read_t unset, output int addr);
		logic [ST_W-1:0] stk [STACK_DEPTH];
		int              cnt;
		int              chain;
		int              plen;
		action_t         act;
		rule_t           rule;
		logic [ST_W-1:0] under;
		logic [EC_W-1:0] cause;
		res_t            outcome [$];
		bit              done;
		stk = parse_stack;
		cnt = parse_depth;
		chain = 0;
		done = 1'b0;
		unset = UNSET_NONE;
		addr = 0;
		while (!done) begin
			addr = int'(stk[cnt-1]) * NUM_TERMINALS + int'(col);
			if (!action_known[addr]) begin
				unset = UNSET_ACTION;
				return 1'b0;
			end
			act = action_tbl[addr];
			cause = EC_NONE;
			done = 1'b1;
			case (act.kind)
				AK_ERROR: cause = EC_ENTRY;
				AK_ACCEPT: begin
					outcome = {outcome,
						make_result(RK_ACCEPT, '0, stk[cnt-1], cnt, EC_NONE, 1'b1)};
					cnt = 0;
				end
				AK_SHIFT: begin
					if (cnt >= STACK_DEPTH) begin
						cause = EC_OVERFLOW;
					end else begin
						stk[cnt] = act.val;
						cnt++;
						outcome = {outcome,
							make_result(RK_SHIFT, '0, act.val, cnt, EC_NONE, 1'b1)};
					end
				end
				default: begin
					// reduce: pop the right-hand side, push the goto target
					if (chain >= MAX_CHAIN) begin
						cause = EC_CHAIN;
					end else begin
						if (!rule_known[act.val]) begin
							unset = UNSET_RULE;
							addr = int'(act.val);
							return 1'b0;
						end
						rule = rule_tbl[act.val];
						plen = int'(rule.len);
						if (plen >= cnt) begin
							cause = EC_UNDERFLOW;
						end else if (plen == 0 && cnt >= STACK_DEPTH) begin
							cause = EC_OVERFLOW;
						end else begin
							under = stk[cnt-plen-1];
							addr = int'(under) * NUM_NONTERMINALS + int'(rule.lhs);
							if (!goto_known[addr]) begin
								unset = UNSET_GOTO;
								return 1'b0;
							end
							cnt = cnt - plen;
							stk[cnt] = goto_tbl[addr];
							cnt++;
							outcome = {outcome, make_result(RK_REDUCE, act.val, stk[cnt-1],
								cnt, EC_NONE, 1'b0)};
							chain++;
							done = 1'b0;
						end
					end
				end
			endcase
			// errors report the stack as it stood, then restart
			if (cause != EC_NONE) begin
				outcome = {outcome, make_result(RK_ERROR, '0, stk[cnt-1], cnt, cause, 1'b1)};
				cnt = 0;
			end
		end
		if (cnt == 0) begin
			cnt = 1;
			stk[0] = '0;
		end
		if (commit) begin
			parse_stack = stk;
			parse_depth = cnt;
			awaited_results = {awaited_results, outcome};
		end
		return 1'b1;
	endfunction

	// Update the tables or the stack for an item the block has taken
	function automatic void take_item(input item_t it);
		unset_read_t unset;
		int          addr;
		items_taken++;
		case (it.op)
			OP_ACT_WR: begin
				addr = int'(it.row) * NUM_TERMINALS + int'(it.col);
				action_tbl[addr] = {it.kind, it.val};
				action_known[addr] = 1'b1;
			end
			OP_GOTO_WR: begin
				addr = int'(it.row) * NUM_NONTERMINALS + int'(it.col);
				goto_tbl[addr] = it.val;
				goto_known[addr] = 1'b1;
			end
			OP_PROD_WR: begin
				rule_tbl[it.pid] = {it.lhs, it.len};
				rule_known[it.pid] = 1'b1;
			end
			default: void'(parse_token(it.col, 1'b1, unset, addr));
		endcase
		if (it.op != OP_TOKEN)
			awaited_results = {awaited_results, make_result(RK_WRITE, '0,
				parse_stack[parse_depth-1], parse_depth, EC_NONE, 1'b1)};
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Called and returns at a falling edge; valid stays up for a back-to-back item
	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{op, row_state, column, production_id, entry_kind, entry_value, lhs_symbol,
			rhs_length} = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		take_item(it);
		@(negedge clk);
	endtask

	// Item constructors: fields the op does not use carry random bits
	function automatic item_t noise_item(input logic [1:0] code);
		item_t it;
		it.op = code;
		it.row = ST_W'($urandom);
		it.col = COL_W'($urandom);
		it.pid = PROD_W'($urandom);
		it.kind = KIND_W'($urandom);
		it.val = ST_W'($urandom);
		it.lhs = NT_W'($urandom);
		it.len = LEN_W'($urandom);
		return it;
	endfunction

	function automatic item_t action_item(input logic [ST_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [KIND_W-1:0] kind,
			input logic [ST_W-1:0] val);
		item_t it;
		it = noise_item(OP_ACT_WR);
		it.row = row;
		it.col = col;
		it.kind = kind;
		it.val = val;
		return it;
	endfunction

	function automatic item_t goto_item(input logic [ST_W-1:0] row,
			input logic [NT_W-1:0] sym, input logic [ST_W-1:0] target);
		item_t it;
		it = noise_item(OP_GOTO_WR);
		it.row = row;
		it.col = sym;
		it.val = target;
		return it;
	endfunction

	function automatic item_t rule_item(input logic [PROD_W-1:0] pid,
			input logic [NT_W-1:0] lhs, input logic [LEN_W-1:0] len);
		item_t it;
		it = noise_item(OP_PROD_WR);
		it.pid = pid;
		it.lhs = lhs;
		it.len = len;
		return it;
	endfunction

	// Random grammar content, mostly drawn from a small set of states and symbols
	function automatic logic [ST_W-1:0] pick_state();
		if ($urandom_range(0, 4) != 0)
			return ST_W'($urandom_range(0, 11));
		return ST_W'($urandom_range(0, NUM_STATES - 1));
	endfunction

	function automatic logic [COL_W-1:0] pick_column();
		if ($urandom_range(0, 4) != 0)
			return COL_W'($urandom_range(0, 5));
		return COL_W'($urandom_range(0, NUM_TERMINALS - 1));
	endfunction

	function automatic logic [NT_W-1:0] pick_symbol();
		if ($urandom_range(0, 6) != 0)
			return NT_W'($urandom_range(0, 3));
		return NT_W'($urandom_range(0, NUM_NONTERMINALS - 1));
	endfunction

	function automatic logic [PROD_W-1:0] pick_rule_slot();
		if ($urandom_range(0, 6) != 0)
			return PROD_W'($urandom_range(0, 7));
		return PROD_W'($urandom_range(0, NUM_PRODUCTIONS - 1));
	endfunction

	function automatic action_t pick_action();
		action_t a;
		int      r;
		r = $urandom_range(0, 99);
		a.val = ST_W'($urandom);
		if (r < 40) begin
			a.kind = AK_SHIFT;
			a.val = pick_state();
		end else if (r < 70) begin
			a.kind = AK_REDUCE;
			a.val = pick_rule_slot();
		end else if (r < 82) begin
			a.kind = AK_ACCEPT;
		end else begin
			a.kind = AK_ERROR;
		end
		return a;
	endfunction

	function automatic rule_t pick_rule();
		rule_t p;
		int    r;
		r = $urandom_range(0, 99);
		p.lhs = pick_symbol();
		if (r < 20)
			p.len = '0;
		else if (r < 70)
			p.len = LEN_W'(1);
		else if (r < 90)
			p.len = LEN_W'($urandom_range(2, 3));
		else
			p.len = LEN_W'($urandom_range(4, 15));
		return p;
	endfunction

	// Write that fills the entry a token would otherwise read unwritten
	function automatic item_t fill_item(input unset_read_t what, input int addr);
		action_t a;
		rule_t   p;
		case (what)
			UNSET_ACTION: begin
				a = pick_action();
				return action_item(ST_W'(addr / NUM_TERMINALS), COL_W'(addr % NUM_TERMINALS),
					a.kind, a.val);
			end
			UNSET_RULE: begin
				p = pick_rule();
				return rule_item(PROD_W'(addr), p.lhs, p.len);
			end
			default: return goto_item(ST_W'(addr / NUM_NONTERMINALS),
				NT_W'(addr % NUM_NONTERMINALS), pick_state());
		endcase
	endfunction

	function automatic item_t grammar_edit();
		action_t a;
		rule_t   p;
		case ($urandom_range(0, 2))
			0: begin
				a = pick_action();
				return action_item(pick_state(), pick_column(), a.kind, a.val);
			end
			1: return goto_item(pick_state(), pick_symbol(), pick_state());
			default: begin
				p = pick_rule();
				return rule_item(pick_rule_slot(), p.lhs, p.len);
			end
		endcase
	endfunction

	// Present a token, first writing any table entry it would reach unwritten
	task automatic present_token(input logic [COL_W-1:0] col);
		unset_read_t unset;
		int          addr;
		item_t       it;
		while (!parse_token(col, 1'b0, unset, addr))
			send_item(fill_item(unset, addr));
		it = noise_item(OP_TOKEN);
		it.col = col;
		send_item(it);
	endtask

	// Write acknowledges at the extremes of every field
	task automatic test_write_acks();
		send_item(action_item(6'd63, 4'd15, AK_ACCEPT, 6'd63));
		send_item(goto_item(6'd63, 4'd15, 6'd63));
		send_item(rule_item(6'd63, 4'd15, 4'd15));
		send_item(rule_item(6'd0, 4'd0, 4'd0));
		send_item(action_item(6'd0, 4'd0, AK_ERROR, 6'd0));
	endtask

	// Shift, accept and error entry
	task automatic test_shift_accept_error();
		send_item(action_item(6'd0, 4'd1, AK_SHIFT, 6'd5));
		send_item(action_item(6'd5, 4'd2, AK_ACCEPT, 6'd0));
		send_item(action_item(6'd5, 4'd3, AK_ERROR, 6'd63));
		present_token(4'd1);
		present_token(4'd2);
		present_token(4'd1);
		present_token(4'd3);
		present_token(4'd0);
	endtask

	// Two reductions in one chain, then underflow
	task automatic test_reduce_chain();
		send_item(action_item(6'd0, 4'd4, AK_SHIFT, 6'd6));
		send_item(action_item(6'd6, 4'd5, AK_REDUCE, 6'd1));
		send_item(rule_item(6'd1, 4'd2, 4'd1));
		send_item(goto_item(6'd0, 4'd2, 6'd7));
		send_item(action_item(6'd7, 4'd5, AK_REDUCE, 6'd2));
		send_item(rule_item(6'd2, 4'd3, 4'd1));
		send_item(goto_item(6'd0, 4'd3, 6'd8));
		send_item(action_item(6'd8, 4'd5, AK_ACCEPT, 6'd0));
		send_item(action_item(6'd0, 4'd6, AK_REDUCE, 6'd3));
		send_item(rule_item(6'd3, 4'd0, 4'd1));
		present_token(4'd4);
		present_token(4'd5);
		present_token(4'd6);
	endtask

	// State 9 shifts itself on column 7 and reduces an empty rule back to
	// itself on column 8: chain limit, reduce overflow, shift overflow
	task automatic test_stack_limits();
		send_item(action_item(6'd0, 4'd7, AK_SHIFT, 6'd9));
		send_item(action_item(6'd9, 4'd7, AK_SHIFT, 6'd9));
		send_item(action_item(6'd9, 4'd8, AK_REDUCE, 6'd4));
		send_item(rule_item(6'd4, 4'd1, 4'd0));
		send_item(goto_item(6'd9, 4'd1, 6'd9));
		present_token(4'd7);
		present_token(4'd8);
		present_token(4'd7);
		present_token(4'd7);
		present_token(4'd8);
		repeat (STACK_DEPTH) present_token(4'd7);
	endtask

	// Mostly tokens over a grammar that grows and mutates, some random writes
	task automatic test_random_parsing();
		int stop_at;
		int r;
		stop_at = items_taken + 300;
		while (items_taken < stop_at) begin
			if ($urandom_range(0, 59) == 0)
				steady = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 70)
				present_token(pick_column());
			else if (r < 88)
				send_item(grammar_edit());
			else
				send_item(noise_item(2'($urandom_range(OP_ACT_WR, OP_PROD_WR))));
		end
		steady = 1'b0;
	endtask

	// Result side stall pattern
	always @(negedge clk) begin
		if (steady || !arst_n) begin
			stall_run = 0;
			out_stall <= 1'b0;
		end else begin
			if (stall_run == 0) begin
				stall_pick = $urandom_range(0, 99);
				if (stall_pick < 50) begin
					stall_level = 1'b0;
					stall_run = $urandom_range(1, 6);
				end else if (stall_pick < 92) begin
					stall_level = 1'b1;
					stall_run = $urandom_range(1, 3);
				end else begin
					stall_level = 1'b1;
					stall_run = $urandom_range(10, 40);
				end
			end
			stall_run--;
			out_stall <= stall_level;
		end
	end

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Compare each taken result with the oldest one awaited
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t ns: unexpected result kind %0d top %0d depth %0d", $time,
						result_kind, top_state, depth);
			end else begin
				want = awaited_results.pop_front();
				compare_field("result_kind", 8'(want.kind), 8'(result_kind));
				compare_field("reduced_production", 8'(want.prod), 8'(reduced_production));
				compare_field("top_state", 8'(want.top), 8'(top_state));
				compare_field("depth", 8'(want.depth), 8'(depth));
				compare_field("error_cause", 8'(want.cause), 8'(error_cause));
				compare_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		{op, row_state, column, production_id, entry_kind, entry_value, lhs_symbol,
			rhs_length} = '0;
		parse_depth = 1;
		parse_stack[0] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_write_acks();
		test_shift_accept_error();
		test_reduce_chain();
		test_stack_limits();
		test_random_parsing();
		in_valid = 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("[lr_shift_reduce_parser] OK");
		else
			$display("[lr_shift_reduce_parser] ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[lr_shift_reduce_parser] ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lrp_pkg.sv
hw/rtl/lrp_tables.sv
hw/rtl/lrp_stack.sv
hw/rtl/lrp_ctrl.sv
hw/rtl/lr_shift_reduce_parser.sv
hw/rtl/lrp_checker.sv
test/lr_shift_reduce_parser_tb.sv
